FILE: sv/epsa_pkg.sv
// package for the elastic-plastic spring axis block: payload types, codes, constants
`default_nettype none
package epsa_pkg;

    localparam int AXES_DEF      = 6;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LIN_AXES      = 3;
    localparam int ENT_W         = 126;

    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

    localparam logic [2:0] AX_LIN_CHECK = 3'd2;
    localparam logic [2:0] AX_ANG_CHECK = 3'd5;

    localparam logic [3:0] CFG_FRAME_RATE   = 4'd0;
    localparam logic [3:0] CFG_SOLVER_ITERS = 4'd1;
    localparam logic [3:0] CFG_MAX_STRAIN   = 4'd2;
    localparam logic [3:0] CFG_MAX_ROTATION = 4'd3;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_REST   = 2'd1,
        CMD_DRIVE  = 2'd2,
        CMD_PLASTIC = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_FORCE,
        S_VFDIV,
        S_TMLO,
        S_TMHI,
        S_MFLSET,
        S_MFLDIV,
        S_MFLGET,
        S_ELDIV,
        S_PLAS,
        S_OUT
    } state_t;

    typedef struct packed {
        cmd_t               command;
        logic [2:0]         axis;
        logic signed [31:0] position;
        logic signed [31:0] applied_force;
        logic [30:0]        stiffness;
        logic [30:0]        damping;
        logic [30:0]        force_limit;
        logic               spring_on;
    } item_t;

    typedef struct packed {
        logic signed [31:0] target_velocity;
        logic [30:0]        motor_force_limit;
        logic signed [31:0] rest_point;
        logic [30:0]        plastic_total;
        logic               yielded;
        logic               axis_active;
        logic               joint_enabled;
    } result_t;

    typedef struct packed {
        logic               on;
        logic signed [31:0] rest;
        logic [30:0]        lim;
        logic [30:0]        damp;
        logic [30:0]        stiff;
    } entry_t;

endpackage
`default_nettype wire

FILE: sv/epsa_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module epsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                clk,
    input  wire logic                                wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                    wr_data,
    input  wire logic                                rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/elastic_plastic_spring_axis.sv
// elastic-plastic spring for the axes of a joint, axis table in ram, shared divider
//
// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------
// request   | start / busy               | item     (epsa_pkg::item_t)
// result    | done, one cycle strobe     | result   (epsa_pkg::result_t)
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// load and set rest do not use the divider; a plastic update uses it when a yield
// needs the elastic reach, a spring drive for the velocity factor and the motor limit;
// the one-bit-per-cycle divider is DIV_W = max(41, 31+FRAC_BITS) bits wide, 47 at default,
// and is shared by velocity factor, motor limit and elastic reach; busy is high from
// the request until the result strobe
// reset returns table entries to defaults through per-entry valid bits
// config writes are taken every cycle; the result cannot be stalled
`default_nettype none
module elastic_plastic_spring_axis #(
    parameter int AXES      = epsa_pkg::AXES_DEF,
    parameter int FRAC_BITS = epsa_pkg::FRAC_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire epsa_pkg::item_t  item,
    output logic                  done,
    output epsa_pkg::result_t     result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [3:0]       cfg_index,
    input  wire logic [31:0]      cfg_data
);

    localparam int IW    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int DIV_W = (31 + FRAC_BITS > 41) ? 31 + FRAC_BITS : 41;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int SUM_W = DIV_W + 31;
    localparam logic [30:0] ONE_Q = 31'(64'd1 << FRAC_BITS);

    epsa_pkg::state_t state_reg, state_next;

    // configuration
    logic [9:0]  fr_reg, si_reg;
    logic [30:0] max_lin_reg, max_ang_reg;

    // persistent state outside the ram
    logic [AXES-1:0] vld_reg;
    logic [30:0]     lin_tot_reg, ang_tot_reg;
    logic            joint_reg;

    // per-item control
    logic done_reg, drv_reg, yld_reg;

    // datapath
    epsa_pkg::item_t   item_reg;
    epsa_pkg::result_t result_reg;
    logic signed [31:0] rest_reg;
    logic               on_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [30:0]        fm_reg, tm_reg, mfl_reg;
    logic [DIV_W-1:0]   div_num_reg;
    logic [30:0]        div_den_reg, div_rem_reg;
    logic [CNT_W-1:0]   div_cnt_reg;

    // ram
    logic                    ram_wr_en, ram_rd_en;
    logic [IW-1:0]           ram_rd_addr;
    epsa_pkg::entry_t        ram_wr_data;
    logic [epsa_pkg::ENT_W-1:0] ram_rd_data;

    epsa_ram #(
        .WIDTH (epsa_pkg::ENT_W),
        .DEPTH (AXES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (item_reg.axis[IW-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // combinational datapath
    logic               ax_ok, lin, path_on;
    epsa_pkg::entry_t   ent;
    logic signed [32:0] delta, fin33;
    logic [32:0]        dmag, fmag;
    logic [63:0]        prod_f, f_sh;
    logic [30:0]        fm_calc;
    logic [40:0]        vf_prod;
    logic [31:0]        rem_sh;
    logic               div_ge;
    logic [31:0]        rem_sub;
    logic               div_last;
    logic [DIV_W-1:0]   div_num_step;
    logic [DIV_W-2:0]   p_hi;
    logic [SUM_W-1:0]   tm_sum, tm_sh;
    logic [30:0]        tm_calc;
    logic [30:0]        el;
    logic signed [32:0] rest_wide;
    logic signed [31:0] rest_new;
    logic [33:0]        tot_sum;
    logic [30:0]        tot_new, lin_next, ang_next;
    logic               joint_next;
    logic signed [31:0] tv;

    always_comb
    begin
        ax_ok   = item_reg.axis < 3'(AXES);
        lin     = item_reg.axis < 3'(epsa_pkg::LIN_AXES);
        path_on = ax_ok && joint_reg;

        if (vld_reg[item_reg.axis[IW-1:0]])
        begin
            ent = epsa_pkg::entry_t'(ram_rd_data);
        end
        else
        begin
            ent = '{on: 1'b0, rest: 32'sd0, lim: ONE_Q, damp: ONE_Q, stiff: 31'd0};
        end

        delta = $signed({item_reg.position[31], item_reg.position})
              - $signed({ent.rest[31], ent.rest});
        dmag  = delta[32] ? 33'(-delta) : 33'(delta);
        fin33 = $signed({item_reg.applied_force[31], item_reg.applied_force});
        fmag  = fin33[32] ? 33'(-fin33) : 33'(fin33);

        prod_f  = {31'd0, dmag} * {33'd0, ent.stiff};
        f_sh    = prod_reg >> FRAC_BITS;
        fm_calc = (f_sh > {33'd0, ent.lim}) ? ent.lim : f_sh[30:0];
        vf_prod = {31'd0, fr_reg} * {10'd0, ent.damp};

        // restoring divider, one quotient bit per cycle
        rem_sh       = {div_rem_reg, div_num_reg[DIV_W-1]};
        div_ge       = rem_sh >= {1'b0, div_den_reg};
        rem_sub      = div_ge ? (rem_sh - {1'b0, div_den_reg}) : rem_sh;
        div_num_step = {div_num_reg[DIV_W-2:0], div_ge};
        div_last     = div_cnt_reg == CNT_W'(DIV_W - 1);

        // velocity factor times force, high part of the factor on top
        p_hi    = (DIV_W-1)'(div_num_reg[DIV_W-1:32]) * (DIV_W-1)'(fm_reg);
        tm_sum  = {p_hi, 32'd0} + SUM_W'(prod_reg);
        tm_sh   = tm_sum >> FRAC_BITS;
        tm_calc = (tm_sh > SUM_W'(epsa_pkg::SAT31)) ? epsa_pkg::SAT31 : tm_sh[30:0];

        if (ent.stiff == 31'd0)
        begin
            el = 31'd0;
        end
        else if (div_num_reg > DIV_W'(epsa_pkg::SAT31))
        begin
            el = epsa_pkg::SAT31;
        end
        else
        begin
            el = div_num_reg[30:0];
        end

        if (item_reg.position > 32'sd0)
        begin
            rest_wide = $signed({item_reg.position[31], item_reg.position})
                      - $signed({2'b00, el});
        end
        else
        begin
            rest_wide = $signed({item_reg.position[31], item_reg.position})
                      + $signed({2'b00, el});
        end
        if (rest_wide > 33'sh0_7FFF_FFFF)
        begin
            rest_new = 32'sh7FFF_FFFF;
        end
        else if (rest_wide < -33'sh0_8000_0000)
        begin
            rest_new = -32'sh8000_0000;
        end
        else
        begin
            rest_new = rest_wide[31:0];
        end

        tot_sum = {3'd0, lin ? lin_tot_reg : ang_tot_reg} + {1'b0, dmag};
        tot_new = (tot_sum > 34'(epsa_pkg::SAT31)) ? epsa_pkg::SAT31 : tot_sum[30:0];
        lin_next = (yld_reg && lin) ? tot_new : lin_tot_reg;
        ang_next = (yld_reg && !lin) ? tot_new : ang_tot_reg;
        joint_next = joint_reg;
        if (item_reg.axis == epsa_pkg::AX_LIN_CHECK && lin_next > max_lin_reg)
        begin
            joint_next = 1'b0;
        end
        if (item_reg.axis == epsa_pkg::AX_ANG_CHECK && ang_next > max_ang_reg)
        begin
            joint_next = 1'b0;
        end

        if (!drv_reg || fm_reg == 31'd0)
        begin
            tv = 32'sd0;
        end
        else if (neg_reg)
        begin
            tv = -$signed({1'b0, tm_reg});
        end
        else
        begin
            tv = $signed({1'b0, tm_reg});
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            epsa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = epsa_pkg::S_EVAL;
                end
            end
            epsa_pkg::S_EVAL:
            begin
                state_next = epsa_pkg::S_OUT;
                if (path_on && item_reg.command == epsa_pkg::CMD_DRIVE && ent.on)
                begin
                    state_next = epsa_pkg::S_FORCE;
                end
                else if (path_on && item_reg.command == epsa_pkg::CMD_PLASTIC)
                begin
                    if (ent.on && fmag > {2'b00, ent.lim} && ent.stiff != 31'd0)
                    begin
                        state_next = epsa_pkg::S_ELDIV;
                    end
                    else
                    begin
                        state_next = epsa_pkg::S_PLAS;
                    end
                end
            end
            epsa_pkg::S_FORCE:
            begin
                state_next = (si_reg == 10'd0) ? epsa_pkg::S_MFLSET : epsa_pkg::S_VFDIV;
            end
            epsa_pkg::S_VFDIV:
            begin
                if (div_last)
                begin
                    state_next = epsa_pkg::S_TMLO;
                end
            end
            epsa_pkg::S_TMLO:
            begin
                state_next = epsa_pkg::S_TMHI;
            end
            epsa_pkg::S_TMHI:
            begin
                state_next = epsa_pkg::S_MFLSET;
            end
            epsa_pkg::S_MFLSET:
            begin
                state_next = (fr_reg == 10'd0) ? epsa_pkg::S_OUT : epsa_pkg::S_MFLDIV;
            end
            epsa_pkg::S_MFLDIV:
            begin
                if (div_last)
                begin
                    state_next = epsa_pkg::S_MFLGET;
                end
            end
            epsa_pkg::S_MFLGET:
            begin
                state_next = epsa_pkg::S_OUT;
            end
            epsa_pkg::S_ELDIV:
            begin
                if (div_last)
                begin
                    state_next = epsa_pkg::S_PLAS;
                end
            end
            epsa_pkg::S_PLAS:
            begin
                state_next = epsa_pkg::S_OUT;
            end
            epsa_pkg::S_OUT:
            begin
                state_next = epsa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = epsa_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and ram controls
    always_comb
    begin
        busy        = state_reg != epsa_pkg::S_IDLE;
        cfg_ready   = 1'b1;
        done        = done_reg;
        result      = result_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = item.axis[IW-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_data = ent;
        case (state_reg)
            epsa_pkg::S_IDLE:
            begin
                ram_rd_en = start;
            end
            epsa_pkg::S_EVAL:
            begin
                if (path_on && item_reg.command == epsa_pkg::CMD_LOAD)
                begin
                    ram_wr_en         = 1'b1;
                    ram_wr_data.on    = item_reg.spring_on;
                    ram_wr_data.lim   = item_reg.force_limit;
                    ram_wr_data.damp  = item_reg.damping;
                    ram_wr_data.stiff = item_reg.stiffness;
                end
                else if (path_on && item_reg.command == epsa_pkg::CMD_REST)
                begin
                    ram_wr_en        = 1'b1;
                    ram_wr_data.rest = item_reg.position;
                end
            end
            epsa_pkg::S_PLAS:
            begin
                ram_wr_en        = yld_reg;
                ram_wr_data.rest = rest_new;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= epsa_pkg::S_IDLE;
            fr_reg      <= 10'd60;
            si_reg      <= 10'd10;
            max_lin_reg <= 31'd0;
            max_ang_reg <= 31'd0;
            vld_reg     <= '0;
            lin_tot_reg <= 31'd0;
            ang_tot_reg <= 31'd0;
            joint_reg   <= 1'b1;
            done_reg    <= 1'b0;
            drv_reg     <= 1'b0;
            yld_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == epsa_pkg::S_OUT;
            if (cfg_valid)
            begin
                case (cfg_index)
                    epsa_pkg::CFG_FRAME_RATE:   fr_reg      <= cfg_data[9:0];
                    epsa_pkg::CFG_SOLVER_ITERS: si_reg      <= cfg_data[9:0];
                    epsa_pkg::CFG_MAX_STRAIN:   max_lin_reg <= cfg_data[30:0];
                    epsa_pkg::CFG_MAX_ROTATION: max_ang_reg <= cfg_data[30:0];
                    default:                    fr_reg      <= fr_reg;
                endcase
            end
            if (ram_wr_en)
            begin
                vld_reg[item_reg.axis[IW-1:0]] <= 1'b1;
            end
            if (state_reg == epsa_pkg::S_IDLE && start)
            begin
                drv_reg <= 1'b0;
                yld_reg <= 1'b0;
            end
            if (state_reg == epsa_pkg::S_EVAL)
            begin
                drv_reg <= path_on && item_reg.command == epsa_pkg::CMD_DRIVE && ent.on;
                yld_reg <= path_on && item_reg.command == epsa_pkg::CMD_PLASTIC && ent.on
                           && fmag > {2'b00, ent.lim};
            end
            if (state_reg == epsa_pkg::S_PLAS)
            begin
                lin_tot_reg <= lin_next;
                ang_tot_reg <= ang_next;
                joint_reg   <= joint_next;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            epsa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_reg <= item;
                end
            end
            epsa_pkg::S_EVAL:
            begin
                rest_reg <= (path_on && item_reg.command == epsa_pkg::CMD_REST)
                            ? item_reg.position : ent.rest;
                on_reg   <= (path_on && item_reg.command == epsa_pkg::CMD_LOAD)
                            ? item_reg.spring_on : ent.on;
                prod_reg <= prod_f;
                neg_reg  <= delta[32] ^ !lin;
                // elastic reach: limit shifted up over stiffness
                div_num_reg <= DIV_W'(ent.lim) << FRAC_BITS;
                div_den_reg <= ent.stiff;
                div_rem_reg <= 31'd0;
                div_cnt_reg <= '0;
            end
            epsa_pkg::S_FORCE:
            begin
                fm_reg      <= fm_calc;
                tm_reg      <= (fm_calc != 31'd0) ? epsa_pkg::SAT31 : 31'd0;
                div_num_reg <= DIV_W'(vf_prod);
                div_den_reg <= {21'd0, si_reg};
                div_rem_reg <= 31'd0;
                div_cnt_reg <= '0;
            end
            epsa_pkg::S_VFDIV, epsa_pkg::S_MFLDIV, epsa_pkg::S_ELDIV:
            begin
                div_num_reg <= div_num_step;
                div_rem_reg <= rem_sub[30:0];
                div_cnt_reg <= div_cnt_reg + CNT_W'(1);
            end
            epsa_pkg::S_TMLO:
            begin
                prod_reg <= {32'd0, div_num_reg[31:0]} * {33'd0, fm_reg};
            end
            epsa_pkg::S_TMHI:
            begin
                tm_reg <= tm_calc;
            end
            epsa_pkg::S_MFLSET:
            begin
                mfl_reg     <= (fm_reg != 31'd0) ? epsa_pkg::SAT31 : 31'd0;
                div_num_reg <= DIV_W'(fm_reg);
                div_den_reg <= {21'd0, fr_reg};
                div_rem_reg <= 31'd0;
                div_cnt_reg <= '0;
            end
            epsa_pkg::S_MFLGET:
            begin
                mfl_reg <= div_num_reg[30:0];
            end
            epsa_pkg::S_PLAS:
            begin
                if (yld_reg)
                begin
                    rest_reg <= rest_new;
                end
            end
            epsa_pkg::S_OUT:
            begin
                result_reg.target_velocity   <= tv;
                result_reg.motor_force_limit <= drv_reg ? mfl_reg : 31'd0;
                result_reg.rest_point        <= ax_ok ? rest_reg : 32'sd0;
                result_reg.plastic_total     <= lin ? lin_tot_reg : ang_tot_reg;
                result_reg.yielded           <= yld_reg;
                result_reg.axis_active       <= ax_ok && on_reg && joint_reg;
                result_reg.joint_enabled     <= joint_reg;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: tb/epsa_checker.sv
// checker for the spring axis block: predicts each result and compares it field by field
module epsa_checker
    import epsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire item_t       item,
    input  wire logic        done,
    input  wire result_t     result,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending
);

    localparam logic [63:0] SAT = 64'h7FFF_FFFF;

    logic [9:0]  m_frame_rate;
    logic [9:0]  m_iters;
    logic [30:0] m_max_strain;
    logic [30:0] m_max_rot;
    logic [63:0] m_stiff [AXES_DEF];
    logic [63:0] m_damp  [AXES_DEF];
    logic [63:0] m_lim   [AXES_DEF];
    logic signed [63:0] m_rest [AXES_DEF];
    logic        m_on    [AXES_DEF];
    logic [63:0] m_lin_total;
    logic [63:0] m_ang_total;
    logic        m_joint;

    result_t     want_q [$];

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // advance the model state by one request and build the expected result
    task automatic spring_step(input item_t it, output result_t r);
        logic [2:0]  ax;
        logic        lin;
        logic        ok;
        logic signed [63:0] pos;
        logic signed [63:0] delta;
        logic signed [63:0] tv;
        logic [63:0] fm;
        logic [63:0] vf;
        logic [63:0] tm;
        logic [63:0] mfl;
        logic [63:0] el;
        logic [63:0] tot;
        logic [127:0] prod;
        logic        neg;
        logic        yld;
        ax  = it.axis;
        lin = ax < LIN_AXES;
        ok  = ax < AXES_DEF;
        pos = 64'(it.position);
        tv  = 0;
        mfl = 0;
        yld = 0;
        if (ok && m_joint)
        begin
            case (it.command)
                CMD_LOAD:
                begin
                    m_stiff[ax] = 64'(it.stiffness);
                    m_damp[ax]  = 64'(it.damping);
                    m_lim[ax]   = 64'(it.force_limit);
                    m_on[ax]    = it.spring_on;
                end
                CMD_REST:
                    m_rest[ax] = pos;
                CMD_DRIVE:
                    if (m_on[ax])
                    begin
                        delta = pos - m_rest[ax];
                        fm = (mag(delta) * m_stiff[ax]) >> FRAC_BITS_DEF;
                        if (fm > m_lim[ax])
                            fm = m_lim[ax];
                        neg = (delta < 0) ^ !lin;
                        if (m_iters == 0)
                            tm = (fm != 0) ? SAT : 0;
                        else
                        begin
                            vf = 64'(m_frame_rate) * m_damp[ax] / 64'(m_iters);
                            prod = (128'(vf) * 128'(fm)) >> FRAC_BITS_DEF;
                            tm = (prod > 128'(SAT)) ? SAT : prod[63:0];
                        end
                        tv = (fm == 0) ? 0 : (neg ? -$signed(tm) : $signed(tm));
                        if (m_frame_rate == 0)
                            mfl = (fm != 0) ? SAT : 0;
                        else
                            mfl = fm / 64'(m_frame_rate);
                    end
                default:
                begin
                    if (m_on[ax])
                    begin
                        delta = pos - m_rest[ax];
                        if (mag(64'(it.applied_force)) > m_lim[ax])
                        begin
                            el = 0;
                            if (m_stiff[ax] != 0)
                            begin
                                el = (m_lim[ax] << FRAC_BITS_DEF) / m_stiff[ax];
                                if (el > SAT)
                                    el = SAT;
                            end
                            m_rest[ax] = (pos > 0) ? pos - $signed(el) : pos + $signed(el);
                            if (m_rest[ax] > 64'sd2147483647)
                                m_rest[ax] = 64'sd2147483647;
                            if (m_rest[ax] < -64'sd2147483648)
                                m_rest[ax] = -64'sd2147483648;
                            tot = (lin ? m_lin_total : m_ang_total) + mag(delta);
                            if (tot > SAT)
                                tot = SAT;
                            if (lin)
                                m_lin_total = tot;
                            else
                                m_ang_total = tot;
                            yld = 1;
                        end
                    end
                    // group check runs even with the spring off
                    if (ax == AX_LIN_CHECK && m_lin_total > 64'(m_max_strain))
                        m_joint = 0;
                    if (ax == AX_ANG_CHECK && m_ang_total > 64'(m_max_rot))
                        m_joint = 0;
                end
            endcase
        end
        r.target_velocity   = tv[31:0];
        r.motor_force_limit = mfl[30:0];
        r.rest_point        = ok ? m_rest[ax][31:0] : 32'sd0;
        r.plastic_total     = lin ? m_lin_total[30:0] : m_ang_total[30:0];
        r.yielded           = yld;
        r.axis_active       = ok && m_on[ax] && m_joint;
        r.joint_enabled     = m_joint;
    endtask

    task automatic check_field(input string name, input logic [31:0] w, input logic [31:0] g);
        if (w !== g)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, w, g);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t w;
        if (!rst_n)
        begin
            m_frame_rate = 10'd60;
            m_iters      = 10'd10;
            m_max_strain = '0;
            m_max_rot    = '0;
            for (int i = 0; i < AXES_DEF; i++)
            begin
                m_stiff[i] = 0;
                m_damp[i]  = 64'h1_0000;
                m_lim[i]   = 64'h1_0000;
                m_rest[i]  = 0;
                m_on[i]    = 0;
            end
            m_lin_total = 0;
            m_ang_total = 0;
            m_joint     = 1;
            want_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (want_q.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, actual %h", $time, result);
                    errors++;
                end
                else
                begin
                    w = want_q.pop_front();
                    check_field("target_velocity", w.target_velocity, result.target_velocity);
                    check_field("motor_force_limit", 32'(w.motor_force_limit),
                                32'(result.motor_force_limit));
                    check_field("rest_point", w.rest_point, result.rest_point);
                    check_field("plastic_total", 32'(w.plastic_total),
                                32'(result.plastic_total));
                    check_field("yielded", 32'(w.yielded), 32'(result.yielded));
                    check_field("axis_active", 32'(w.axis_active), 32'(result.axis_active));
                    check_field("joint_enabled", 32'(w.joint_enabled),
                                32'(result.joint_enabled));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FRAME_RATE:   m_frame_rate = cfg_data[9:0];
                    CFG_SOLVER_ITERS: m_iters      = cfg_data[9:0];
                    CFG_MAX_STRAIN:   m_max_strain = cfg_data[30:0];
                    CFG_MAX_ROTATION: m_max_rot    = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                spring_step(item, w);
                want_q.push_back(w);
            end
            pending = want_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
// testbench top for the spring axis block: clock, reset, stimulus and verdict
module tb;
    import epsa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;

    elastic_plastic_spring_axis uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    epsa_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("elastic_plastic_spring_axis regression: fail");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
            2: return $urandom_range(0, 300_000);
            3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom())};
            default: return 32'($signed($urandom_range(0, 600_000)) - 300_000);
        endcase
    endfunction

    function automatic item_t make_request(input cmd_t c, input int ax, input logic [31:0] pos,
                                           input logic [31:0] f, input logic [30:0] st,
                                           input logic [30:0] dp, input logic [30:0] lm,
                                           input logic on);
        item_t it;
        it.command       = c;
        it.axis          = 3'(ax);
        it.position      = pos;
        it.applied_force = f;
        it.stiffness     = st;
        it.damping       = dp;
        it.force_limit   = lm;
        it.spring_on     = on;
        return it;
    endfunction

    function automatic item_t rand_request();
        int   p;
        cmd_t c;
        p = $urandom_range(0, 99);
        if (p < 20)
            c = CMD_LOAD;
        else if (p < 35)
            c = CMD_REST;
        else if (p < 70)
            c = CMD_DRIVE;
        else
            c = CMD_PLASTIC;
        return make_request(c, ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                           : $urandom_range(0, 5),
                            rand_val(), rand_val(),
                            ($urandom_range(0, 1)) ? 31'($urandom()) : 31'($urandom_range(0, 400_000)),
                            ($urandom_range(0, 1)) ? 31'($urandom()) : 31'($urandom_range(0, 200_000)),
                            ($urandom_range(0, 1)) ? 31'($urandom()) : 31'($urandom_range(0, 200_000)),
                            $urandom_range(0, 5) != 0);
    endfunction

    // hold the request until the block takes it, then maybe pause
    task automatic issue(input item_t it);
        int g;
        start = 1;
        item  = it;
        do @(posedge clk); while (busy);
        @(negedge clk);
        g = gap_len();
        if (g > 0)
        begin
            start = 0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        start = 0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [3:0] idx, input logic [31:0] data);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    initial
    begin
        start     = 0;
        item      = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // default registers, spring off and invalid axes first
        issue(make_request(CMD_DRIVE, 0, 32'h0001_0000, 0, 0, 0, 0, 0));
        issue(make_request(CMD_PLASTIC, 6, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1));
        issue(make_request(CMD_LOAD, 7, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1));
        wait_idle();
        cfg_write(CFG_MAX_STRAIN, 32'hFFFF_FFFF);
        cfg_write(CFG_MAX_ROTATION, 32'h7FFF_FFFF);
        cfg_write(4'd9, 32'hFFFF_FFFF);
        issue(make_request(CMD_LOAD, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1));
        issue(make_request(CMD_DRIVE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
        issue(make_request(CMD_DRIVE, 0, 32'h8000_0000, 0, 0, 0, 0, 0));
        issue(make_request(CMD_DRIVE, 0, 0, 0, 0, 0, 0, 0));
        issue(make_request(CMD_LOAD, 4, 0, 0, 31'h0001_0000, 31'h0002_0000, 31'h0000_8000, 1));
        issue(make_request(CMD_REST, 4, 32'h0003_0000, 0, 0, 0, 0, 0));
        issue(make_request(CMD_DRIVE, 4, 32'h0001_0000, 0, 0, 0, 0, 0));
        issue(make_request(CMD_DRIVE, 4, 32'h0005_0000, 0, 0, 0, 0, 0));
        issue(make_request(CMD_PLASTIC, 4, 32'h0004_0000, 32'h0000_1000, 0, 0, 0, 0));
        issue(make_request(CMD_PLASTIC, 4, 32'h0004_0000, 32'hFFF0_0000, 0, 0, 0, 0));
        issue(make_request(CMD_PLASTIC, 4, 32'hFFFC_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
        // zero stiffness puts the rest point on the position
        issue(make_request(CMD_LOAD, 1, 0, 0, 0, 31'h0001_0000, 31'h0000_0100, 1));
        issue(make_request(CMD_PLASTIC, 1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
        issue(make_request(CMD_PLASTIC, 2, 32'h1234_5678, 32'h0010_0000, 0, 0, 0, 0));
        issue(make_request(CMD_PLASTIC, 5, 32'h7FFF_FFFF, 32'h0010_0000, 0, 0, 0, 0));
        issue(make_request(CMD_LOAD, 3, 0, 0, 31'h0000_0001, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1));
        issue(make_request(CMD_PLASTIC, 3, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
        issue(make_request(CMD_DRIVE, 3, 32'h8000_0000, 0, 0, 0, 0, 0));
        wait_idle();

        // register settings, extremes and zero divisors among them
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin cfg_write(CFG_FRAME_RATE, 1);    cfg_write(CFG_SOLVER_ITERS, 1);    end
                1: begin cfg_write(CFG_FRAME_RATE, 1000); cfg_write(CFG_SOLVER_ITERS, 1000); end
                2: begin cfg_write(CFG_FRAME_RATE, 0);    cfg_write(CFG_SOLVER_ITERS, 0);    end
                3: begin cfg_write(CFG_FRAME_RATE, 1023); cfg_write(CFG_SOLVER_ITERS, 3);    end
                4: begin
                       cfg_write(CFG_FRAME_RATE, $urandom());
                       cfg_write(CFG_SOLVER_ITERS, $urandom());
                       cfg_write(4'($urandom_range(4, 15)), $urandom());
                   end
                default:
                   begin
                       // small limits so the joint breaks late in the run
                       cfg_write(CFG_FRAME_RATE, 60);
                       cfg_write(CFG_SOLVER_ITERS, 10);
                       cfg_write(CFG_MAX_STRAIN, $urandom_range(0, 32'h0100_0000));
                       cfg_write(CFG_MAX_ROTATION, 0);
                   end
            endcase
            for (int n = 0; n < 138; n++)
                issue(rand_request());
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("elastic_plastic_spring_axis regression: pass");
        else
            $display("elastic_plastic_spring_axis regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
sv/epsa_pkg.sv
sv/epsa_ram.sv
sv/elastic_plastic_spring_axis.sv
tb/epsa_checker.sv
tb/tb.sv
